@@ hw/rtl/least_work_queue_dispatcher_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the least work queue dispatcher
// Shared property wrappers, clocked on the rising edge, off during reset.
// ----------------------------------------------------------------------------
`ifndef LEAST_WORK_QUEUE_DISPATCHER_UNIT_ASSERT_SVH
`define LEAST_WORK_QUEUE_DISPATCHER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define LWQD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define LWQD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/lwqd_pkg.sv @@
// ----------------------------------------------------------------------------
// lwqd_pkg
// Types and codes shared by the least work queue dispatcher modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lwqd_pkg;

    // Fixed field widths
    localparam int ID_BITS   = 8;
    localparam int WORK_BITS = 8;
    localparam int FUNC_W    = 2;
    localparam int SRV_W     = 2;
    localparam int STAT_W    = 2;

    // Request function codes
    localparam logic [FUNC_W-1:0] FUNC_ARRIVE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READY  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FINISH = 2'd2;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    // One result item
    typedef struct packed {
        logic [1:0]           queue_index;
        logic [ID_BITS-1:0]   released_id;
        logic [WORK_BITS-1:0] released_work;
        logic [4:0]           queue_length;
        logic [11:0]          queue_work_total;
        logic                 serve_granted;
        logic                 wake_server;
        logic [STAT_W-1:0]    status;
    } t_result;

    // Controller to datapath commands
    typedef struct packed {
        logic load;    // capture the request
        logic lookup;  // pick queue, read job store
        logic commit;  // update queue state, load result register
    } t_cmd;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_COMMIT
    } t_state;

endpackage

@@ hw/rtl/lwqd_if.sv @@
// ----------------------------------------------------------------------------
// lwqd_if
// Valid/ready channels for dispatcher requests and results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Request channel
interface lwqd_job_if;
    logic                           valid;
    logic                           ready;
    logic [lwqd_pkg::FUNC_W-1:0]    func;
    logic [lwqd_pkg::ID_BITS-1:0]   job_id;
    logic [lwqd_pkg::WORK_BITS-1:0] work_amount;
    logic [lwqd_pkg::SRV_W-1:0]     server_index;

    modport source (output valid, func, job_id, work_amount, server_index, input ready);
    modport sink   (input valid, func, job_id, work_amount, server_index, output ready);
endinterface

// Result channel
interface lwqd_res_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     queue_index;
    logic [lwqd_pkg::ID_BITS-1:0]   released_id;
    logic [lwqd_pkg::WORK_BITS-1:0] released_work;
    logic [4:0]                     queue_length;
    logic [11:0]                    queue_work_total;
    logic                           serve_granted;
    logic                           wake_server;
    logic [lwqd_pkg::STAT_W-1:0]    status;

    modport source (output valid, queue_index, released_id, released_work, queue_length,
                    queue_work_total, serve_granted, wake_server, status, input ready);
    modport sink   (input valid, queue_index, released_id, released_work, queue_length,
                    queue_work_total, serve_granted, wake_server, status, output ready);
endinterface

@@ hw/rtl/least_work_queue_dispatcher_unit.sv @@
// ----------------------------------------------------------------------------
// least_work_queue_dispatcher_unit
// Dispatches jobs to per-server FIFOs, picking the queue with least work.
//
// Usage:
//   i_job carries one request per transfer: func selects job arrival,
//   server ready or server finished; job_id and work_amount apply to an
//   arrival, server_index to ready and finish.
//   o_res returns exactly one result per request, in request order.
//   An item is taken, then the chosen queue is looked up and the job
//   store read into a register, and then the queue state is updated and
//   the result registered. One request is in flight at a time: a new
//   request is taken only after the current one has been updated.
//   A result waiting in the output register does not stop the next request
//   from being taken; that request holds before its update until the
//   result has been transferred.
//   Reset clears all queue pointers, counts, work totals and waiting flags.
//   The job store needs no clearing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "least_work_queue_dispatcher_unit_assert.svh"

module least_work_queue_dispatcher_unit #(
    parameter int NUM_QUEUES  = 4,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lwqd_job_if.sink   i_job,
    lwqd_res_if.source o_res
);

    lwqd_pkg::t_cmd    w_cmd;
    lwqd_pkg::t_result w_res;

    // Sequencer
    lwqd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_job.valid),
        .o_in_ready  (i_job.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .o_cmd       (w_cmd)
    );

    // Queue state and job store
    lwqd_dpath #(
        .NUM_QUEUES  (NUM_QUEUES),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_func         (i_job.func),
        .i_job_id       (i_job.job_id),
        .i_work_amount  (i_job.work_amount),
        .i_server_index (i_job.server_index),
        .o_res          (w_res)
    );

    // Result fields
    assign o_res.queue_index      = w_res.queue_index;
    assign o_res.released_id      = w_res.released_id;
    assign o_res.released_work    = w_res.released_work;
    assign o_res.queue_length     = w_res.queue_length;
    assign o_res.queue_work_total = w_res.queue_work_total;
    assign o_res.serve_granted    = w_res.serve_granted;
    assign o_res.wake_server      = w_res.wake_server;
    assign o_res.status           = w_res.status;

    // Handshake terms for the checks
    logic w_job_take;
    logic w_res_free;

    assign w_job_take = i_job.valid && i_job.ready;
    assign w_res_free = !o_res.valid || o_res.ready;

    // Checks
    `LWQD_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, w_job_take, !i_job.ready, "taken when busy")
    `LWQD_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, w_cmd.commit, w_res_free, "result overwritten")
    `LWQD_ASSERT_NEXT(a_commit_shows, i_clk, i_rst_n, w_cmd.commit, o_res.valid, "result not shown")

endmodule

@@ hw/rtl/lwqd_ctrl.sv @@
// ----------------------------------------------------------------------------
// lwqd_ctrl
// Sequencer: accept, lookup, commit; owns the result valid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lwqd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output lwqd_pkg::t_cmd o_cmd
);

    lwqd_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;

    // State and result flag registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lwqd_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            lwqd_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = lwqd_pkg::S_LOOKUP;
                end
            end
            lwqd_pkg::S_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                n_state      = lwqd_pkg::S_COMMIT;
            end
            lwqd_pkg::S_COMMIT: begin
                // wait until the result register is free or being drained
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_state      = lwqd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lwqd_pkg::S_IDLE;
            end
        endcase
    end

    // Result valid: set on commit, cleared on transfer
    always_comb begin
        priority if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ hw/rtl/lwqd_dpath.sv @@
// ----------------------------------------------------------------------------
// lwqd_dpath
// Queue state, job store, least-work selection and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lwqd_dpath #(
    parameter int NUM_QUEUES  = 4,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  lwqd_pkg::t_cmd                 i_cmd,
    input  logic [lwqd_pkg::FUNC_W-1:0]    i_func,
    input  logic [lwqd_pkg::ID_BITS-1:0]   i_job_id,
    input  logic [lwqd_pkg::WORK_BITS-1:0] i_work_amount,
    input  logic [lwqd_pkg::SRV_W-1:0]     i_server_index,
    output lwqd_pkg::t_result              o_res
);

    localparam int QIW     = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int PW      = $clog2(QUEUE_DEPTH);
    localparam int CW      = $clog2(QUEUE_DEPTH + 1);
    localparam int TW      = lwqd_pkg::WORK_BITS + CW;
    localparam int STORE_N = NUM_QUEUES * QUEUE_DEPTH;
    localparam int AW      = $clog2(STORE_N);
    localparam int EW      = lwqd_pkg::ID_BITS + lwqd_pkg::WORK_BITS;
    localparam int NQP     = 1 << $clog2(NUM_QUEUES);

    // Captured request
    logic [lwqd_pkg::FUNC_W-1:0]    r_func;
    logic [lwqd_pkg::ID_BITS-1:0]   r_id;
    logic [lwqd_pkg::WORK_BITS-1:0] r_work;
    logic [lwqd_pkg::SRV_W-1:0]     r_srv;

    // Per-queue state
    logic [PW-1:0] r_wptr [NUM_QUEUES];
    logic [PW-1:0] r_rptr [NUM_QUEUES];
    logic [CW-1:0] r_count [NUM_QUEUES];
    logic [TW-1:0] r_total [NUM_QUEUES];
    logic          r_waiting [NUM_QUEUES];

    // Job store
    logic [EW-1:0] r_mem [STORE_N];
    logic [EW-1:0] r_rd_data;

    // Lookup results
    logic [QIW-1:0] r_q;
    logic           r_q_ok;

    lwqd_pkg::t_result r_res;

    // Request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_id   <= i_job_id;
            r_work <= i_work_amount;
            r_srv  <= i_server_index;
        end
    end

    // Least-work tree, ties resolve to the lower index
    logic [TW-1:0]  w_node_tot [2*NQP-1];
    logic [QIW-1:0] w_node_idx [2*NQP-1];

    for (genvar g = 0; g < NQP; g++) begin : g_leaf
        if (g < NUM_QUEUES) begin : g_real
            assign w_node_tot[NQP-1+g] = r_total[g];
            assign w_node_idx[NQP-1+g] = QIW'(g);
        end else begin : g_pad
            assign w_node_tot[NQP-1+g] = '1;
            assign w_node_idx[NQP-1+g] = QIW'(g);
        end
    end

    for (genvar k = 0; k < NQP - 1; k++) begin : g_node
        logic w_take_right;
        assign w_take_right  = w_node_tot[2*k+2] < w_node_tot[2*k+1];
        assign w_node_tot[k] = w_take_right ? w_node_tot[2*k+2] : w_node_tot[2*k+1];
        assign w_node_idx[k] = w_take_right ? w_node_idx[2*k+2] : w_node_idx[2*k+1];
    end

    // Target queue for the captured request
    logic [QIW+1:0] w_srv_ext;
    logic           w_srv_ok;
    logic [QIW-1:0] w_target;
    logic           w_target_ok;
    logic [AW-1:0]  w_rd_addr;

    assign w_srv_ext   = (QIW+2)'(r_srv);
    assign w_srv_ok    = int'(r_srv) < NUM_QUEUES;
    assign w_target    = (r_func == lwqd_pkg::FUNC_ARRIVE) ? w_node_idx[0]
                                                           : w_srv_ext[QIW-1:0];
    assign w_target_ok = (r_func == lwqd_pkg::FUNC_ARRIVE) || w_srv_ok;
    assign w_rd_addr   = w_target_ok ? AW'(w_target) * AW'(QUEUE_DEPTH) + AW'(r_rptr[w_target])
                                     : '0;

    // Lookup registers and store read
    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_q       <= w_target;
            r_q_ok    <= w_target_ok;
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // Commit logic
    logic [CW-1:0]                  w_cnt, n_cnt;
    logic [TW-1:0]                  w_tot, n_tot;
    logic [PW-1:0]                  w_wp, n_wp, w_rp, n_rp;
    logic                           w_wait, n_wait;
    logic                           w_we, w_grant, w_wake;
    logic [lwqd_pkg::STAT_W-1:0]    w_status;
    logic [lwqd_pkg::ID_BITS-1:0]   w_rel_id;
    logic [lwqd_pkg::WORK_BITS-1:0] w_rel_work;
    logic [AW-1:0]                  w_wr_addr;

    assign w_cnt  = r_q_ok ? r_count[r_q] : '0;
    assign w_tot  = r_q_ok ? r_total[r_q] : '0;
    assign w_wp   = r_q_ok ? r_wptr[r_q] : '0;
    assign w_rp   = r_q_ok ? r_rptr[r_q] : '0;
    assign w_wait = r_q_ok ? r_waiting[r_q] : 1'b0;

    always_comb begin
        n_cnt      = w_cnt;
        n_tot      = w_tot;
        n_wp       = w_wp;
        n_rp       = w_rp;
        n_wait     = w_wait;
        w_we       = 1'b0;
        w_grant    = 1'b0;
        w_wake     = 1'b0;
        w_status   = lwqd_pkg::STAT_OK;
        w_rel_id   = '0;
        w_rel_work = '0;
        unique case (r_func)
            lwqd_pkg::FUNC_ARRIVE: begin
                if (w_cnt >= CW'(QUEUE_DEPTH)) begin
                    w_status = lwqd_pkg::STAT_FULL;
                end else begin
                    w_we  = 1'b1;
                    n_wp  = (w_wp == PW'(QUEUE_DEPTH - 1)) ? '0 : w_wp + 1'b1;
                    n_cnt = w_cnt + 1'b1;
                    n_tot = w_tot + TW'(r_work);
                    // first job into an empty queue wakes a waiting server
                    if (w_cnt == '0 && w_wait) begin
                        w_wake = 1'b1;
                        n_wait = 1'b0;
                    end
                end
            end
            lwqd_pkg::FUNC_READY: begin
                if (r_q_ok) begin
                    if (w_cnt != '0) begin
                        w_grant = 1'b1;
                    end else begin
                        n_wait = 1'b1;
                    end
                end
            end
            lwqd_pkg::FUNC_FINISH: begin
                if (r_q_ok) begin
                    if (w_cnt == '0) begin
                        w_status = lwqd_pkg::STAT_EMPTY;
                    end else begin
                        w_rel_id   = r_rd_data[EW-1:lwqd_pkg::WORK_BITS];
                        w_rel_work = r_rd_data[lwqd_pkg::WORK_BITS-1:0];
                        n_rp  = (w_rp == PW'(QUEUE_DEPTH - 1)) ? '0 : w_rp + 1'b1;
                        n_cnt = w_cnt - 1'b1;
                        n_tot = (w_tot >= TW'(w_rel_work)) ? w_tot - TW'(w_rel_work) : '0;
                    end
                end
            end
            default: begin
                // unused code: report only
            end
        endcase
    end

    assign w_wr_addr = AW'(r_q) * AW'(QUEUE_DEPTH) + AW'(w_wp);

    // Store write
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && w_we) begin
            r_mem[w_wr_addr] <= {r_id, r_work};
        end
    end

    // Queue state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int q = 0; q < NUM_QUEUES; q++) begin
                r_wptr[q]    <= '0;
                r_rptr[q]    <= '0;
                r_count[q]   <= '0;
                r_total[q]   <= '0;
                r_waiting[q] <= 1'b0;
            end
        end else if (i_cmd.commit && r_q_ok) begin
            r_wptr[r_q]    <= n_wp;
            r_rptr[r_q]    <= n_rp;
            r_count[r_q]   <= n_cnt;
            r_total[r_q]   <= n_tot;
            r_waiting[r_q] <= n_wait;
        end
    end

    // Result register
    logic [QIW+1:0] w_q_ext;
    logic [CW+4:0]  w_cnt_ext;
    logic [TW+11:0] w_tot_ext;

    assign w_q_ext   = (QIW+2)'(r_q);
    assign w_cnt_ext = (CW+5)'(n_cnt);
    assign w_tot_ext = (TW+12)'(n_tot);

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            // non-arrival requests echo the addressed server, even out of range
            r_res.queue_index      <= (r_func == lwqd_pkg::FUNC_ARRIVE) ? w_q_ext[1:0] : r_srv;
            r_res.released_id      <= w_rel_id;
            r_res.released_work    <= w_rel_work;
            r_res.queue_length     <= r_q_ok ? w_cnt_ext[4:0] : 5'd0;
            r_res.queue_work_total <= r_q_ok ? w_tot_ext[11:0] : 12'd0;
            r_res.serve_granted    <= w_grant;
            r_res.wake_server      <= w_wake;
            r_res.status           <= w_status;
        end
    end

    assign o_res = r_res;

endmodule
